// ===== rtl/vco_pkg.sv =====
package vco_pkg;

    // Face code, face count and corner count.
    typedef logic [2:0] code_t;
    localparam int NumFaces   = 6;
    localparam int NumCorners = 8;

    // Face k sits in element k, so face 0 lands in the lowest bits when packed.
    typedef code_t [NumFaces-1:0]   faces_t;
    // Corner entry k sits in element k (bits 3k+2..3k when packed).
    typedef code_t [NumCorners-1:0] corner_map_t;

    typedef logic [2:0] cell_type_t;
    typedef logic [1:0] turns_t;
    typedef logic [1:0] extra_t;

    // Face slots.
    localparam int FACE_NEG_X = 0;
    localparam int FACE_POS_X = 1;
    localparam int FACE_NEG_Z = 2;
    localparam int FACE_POS_Z = 3;
    localparam int FACE_NEG_Y = 4;
    localparam int FACE_POS_Y = 5;

    // Face codes: none, full square, and the four oriented halves.
    localparam code_t FACE_NONE  = 3'd0;
    localparam code_t FACE_FULL  = 3'd1;
    localparam code_t HALF_FIRST = 3'd2;
    localparam code_t HALF_LAST  = 3'd5;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        cell_type_t cell_type;
        turns_t     turns_x;
        turns_t     turns_y;
        turns_t     turns_z;
    } item_t;

    typedef struct packed {
        faces_t      faces;
        corner_map_t corners;
        extra_t      extra;
    } result_t;

    // Identity corner map, entry k = k (written from entry 7 down to entry 0).
    localparam corner_map_t CORNER_IDENTITY =
        {3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

    // Source corner for each entry of one quarter turn (entry 7 first).
    localparam corner_map_t PERM_X = {3'd3, 3'd2, 3'd7, 3'd6, 3'd1, 3'd0, 3'd5, 3'd4};
    localparam corner_map_t PERM_Y = {3'd5, 3'd7, 3'd4, 3'd6, 3'd1, 3'd3, 3'd0, 3'd2};
    localparam corner_map_t PERM_Z = {3'd6, 3'd2, 3'd4, 3'd0, 3'd7, 3'd3, 3'd5, 3'd1};

    // Step a half-face code k places round the cycle of halves; other codes stay.
    function automatic code_t step_code(input code_t v, input logic [1:0] k);
        logic [1:0] pos;
        pos = 2'(v - HALF_FIRST) + k;
        if (v inside {[HALF_FIRST:HALF_LAST]})
            return HALF_FIRST + code_t'(pos);
        else
            return v;
    endfunction

endpackage

// ===== rtl/voxel_cell_orienter.sv =====
// An accepted transaction goes through the input register and the result register.
// Throughput: one transaction per cycle unless the output stalls; the shape lookup
// and the three axis turns all sit in one combinational pass between those registers.
// Reset: rst_n is asynchronous and active low; it empties both register stages.
// The block holds no other state, so every result depends on its own transaction only.
module voxel_cell_orienter (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cell_type [2:0], turns_x [4:3], turns_y [6:5], turns_z [8:7], zero [15:9]
    input  logic [15:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // face_neg_x [2:0], face_pos_x [5:3], face_neg_z [8:6], face_pos_z [11:9],
    // face_neg_y [14:12], face_pos_y [17:15], corner_map [41:18],
    // extra_triangles [43:42], zero [47:44]
    output logic [47:0] m_axis_tdata
);

    // Stage one holds the accepted transaction; stage two holds the finished result.
    // Each stage may load whenever it is empty or its content moves on in the same
    // cycle, so a stalled output still lets a new transaction enter an empty stage one.
    logic             in_valid_reg, in_valid_next;
    vco_pkg::item_t   in_item_reg,  in_item_next;
    logic             out_valid_reg, out_valid_next;
    vco_pkg::result_t out_result_reg, out_result_next;

    logic             out_ready;
    logic             in_ready;
    vco_pkg::result_t core_result;

    assign out_ready = !out_valid_reg || m_axis_tready;
    assign in_ready  = !in_valid_reg || out_ready;

    assign s_axis_tready = in_ready;

    // All the table and turn logic lives in the core.
    vco_core u_core (
        .item   (in_item_reg),
        .result (core_result)
    );

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        in_item_next    = in_item_reg;
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;

        if (in_ready)
        begin
            in_valid_next = s_axis_tvalid;
            in_item_next  = '{cell_type: s_axis_tdata[2:0],
                              turns_x:   s_axis_tdata[4:3],
                              turns_y:   s_axis_tdata[6:5],
                              turns_z:   s_axis_tdata[8:7]};
        end

        if (out_ready)
        begin
            out_valid_next  = in_valid_reg;
            out_result_next = core_result;
        end
    end

    // Control flops take the reset; the payload flops simply follow.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg    <= in_item_next;
        out_result_reg <= out_result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0,
                            out_result_reg.extra,
                            out_result_reg.corners,
                            out_result_reg.faces};

`ifndef SYNTH
    // An accepted transaction always lands in stage one.
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> in_valid_reg)
        else $error("accepted transaction not held in the input stage");

    // A full input stage with room downstream becomes a result in the next cycle.
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_ready |=> m_axis_tvalid)
        else $error("input stage did not advance to the output");

    // Extra triangles only come from a shape that has faces of its own.
    a_extra_has_faces: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[43:42] != 2'd0) |-> (m_axis_tdata[17:0] != 18'd0))
        else $error("extra triangles reported for an empty cell");
`endif

endmodule

// ===== rtl/vco_turn.sv =====
module vco_turn (
    input  vco_pkg::axis_t       axis,
    input  vco_pkg::turns_t      turns,
    input  vco_pkg::faces_t      faces_in,
    input  vco_pkg::corner_map_t corners_in,
    output vco_pkg::faces_t      faces_out,
    output vco_pkg::corner_map_t corners_out
);

    vco_pkg::faces_t      f_step [4];
    vco_pkg::corner_map_t b_step [4];
    vco_pkg::corner_map_t perm;
    vco_pkg::corner_map_t b_sel;

    always_comb
    begin
        case (axis)
            vco_pkg::AXIS_X: perm = vco_pkg::PERM_X;
            vco_pkg::AXIS_Y: perm = vco_pkg::PERM_Y;
            vco_pkg::AXIS_Z: perm = vco_pkg::PERM_Z;
            default:         perm = vco_pkg::CORNER_IDENTITY;
        endcase
    end

    // Up to three chained quarter turns; the count picks one of the four.
    always_comb
    begin
        f_step[0] = faces_in;
        b_step[0] = corners_in;
        for (int s = 0; s < 3; s++)
        begin
            for (int i = 0; i < vco_pkg::NumCorners; i++)
                b_step[s+1][i] = b_step[s][perm[i]];
            f_step[s+1] = f_step[s];
            case (axis)
                vco_pkg::AXIS_X:
                begin
                    f_step[s+1][vco_pkg::FACE_NEG_Z] =
                        vco_pkg::step_code(f_step[s][vco_pkg::FACE_POS_Y], 2'd2);
                    f_step[s+1][vco_pkg::FACE_POS_Y] = f_step[s][vco_pkg::FACE_POS_Z];
                    f_step[s+1][vco_pkg::FACE_POS_Z] =
                        vco_pkg::step_code(f_step[s][vco_pkg::FACE_NEG_Y], 2'd3);
                    f_step[s+1][vco_pkg::FACE_NEG_Y] =
                        vco_pkg::step_code(f_step[s][vco_pkg::FACE_NEG_Z], 2'd3);
                    f_step[s+1][vco_pkg::FACE_POS_X] =
                        vco_pkg::step_code(f_step[s][vco_pkg::FACE_POS_X], 2'd1);
                    f_step[s+1][vco_pkg::FACE_NEG_X] =
                        vco_pkg::step_code(f_step[s][vco_pkg::FACE_NEG_X], 2'd3);
                end
                vco_pkg::AXIS_Y:
                begin
                    f_step[s+1][vco_pkg::FACE_NEG_X] = f_step[s][vco_pkg::FACE_NEG_Z];
                    f_step[s+1][vco_pkg::FACE_NEG_Z] = f_step[s][vco_pkg::FACE_POS_X];
                    f_step[s+1][vco_pkg::FACE_POS_X] = f_step[s][vco_pkg::FACE_POS_Z];
                    f_step[s+1][vco_pkg::FACE_POS_Z] = f_step[s][vco_pkg::FACE_NEG_X];
                    f_step[s+1][vco_pkg::FACE_POS_Y] =
                        vco_pkg::step_code(f_step[s][vco_pkg::FACE_POS_Y], 2'd3);
                    f_step[s+1][vco_pkg::FACE_NEG_Y] =
                        vco_pkg::step_code(f_step[s][vco_pkg::FACE_NEG_Y], 2'd1);
                end
                vco_pkg::AXIS_Z:
                begin
                    f_step[s+1][vco_pkg::FACE_NEG_X] = f_step[s][vco_pkg::FACE_NEG_Y];
                    f_step[s+1][vco_pkg::FACE_NEG_Y] =
                        vco_pkg::step_code(f_step[s][vco_pkg::FACE_POS_X], 2'd2);
                    f_step[s+1][vco_pkg::FACE_POS_X] =
                        vco_pkg::step_code(f_step[s][vco_pkg::FACE_POS_Y], 2'd1);
                    f_step[s+1][vco_pkg::FACE_POS_Y] =
                        vco_pkg::step_code(f_step[s][vco_pkg::FACE_NEG_X], 2'd1);
                    f_step[s+1][vco_pkg::FACE_POS_Z] =
                        vco_pkg::step_code(f_step[s][vco_pkg::FACE_POS_Z], 2'd1);
                    f_step[s+1][vco_pkg::FACE_NEG_Z] =
                        vco_pkg::step_code(f_step[s][vco_pkg::FACE_NEG_Z], 2'd3);
                end
                default:
                begin
                    f_step[s+1] = f_step[s];
                end
            endcase
        end
    end

    assign faces_out = f_step[turns];
    assign b_sel     = b_step[turns];

    // The stored map is the inverse of the permuted corner order.
    always_comb
    begin
        for (int j = 0; j < vco_pkg::NumCorners; j++)
        begin
            corners_out[j] = '0;
            for (int i = 0; i < vco_pkg::NumCorners; i++)
            begin
                if (b_sel[i] == 3'(j))
                    corners_out[j] = 3'(i);
            end
        end
    end

endmodule

// ===== rtl/vco_core.sv =====
module vco_core (
    input  vco_pkg::item_t   item,
    output vco_pkg::result_t result
);

    localparam vco_pkg::cell_type_t SHAPE_FIRST = 3'd1;
    localparam vco_pkg::cell_type_t SHAPE_LAST  = 3'd6;

    // Base faces per shape type, face 5 written first.
    localparam vco_pkg::faces_t SHAPE_FACES [6] = '{
        {3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
        {3'd0, 3'd1, 3'd0, 3'd1, 3'd5, 3'd2},
        {3'd0, 3'd3, 3'd0, 3'd5, 3'd0, 3'd2},
        {3'd0, 3'd1, 3'd0, 3'd5, 3'd0, 3'd2},
        {3'd3, 3'd1, 3'd2, 3'd1, 3'd5, 3'd1},
        {3'd3, 3'd5, 3'd2, 3'd3, 3'd5, 3'd4}
    };
    localparam vco_pkg::extra_t SHAPE_EXTRA [6] = '{2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2};

    vco_pkg::cell_type_t  row;
    vco_pkg::faces_t      base_faces;
    vco_pkg::extra_t      base_extra;
    vco_pkg::faces_t      faces_x, faces_y, faces_z;
    vco_pkg::corner_map_t corners_x, corners_y, corners_z;

    assign row = item.cell_type - SHAPE_FIRST;

    // Shape types outside the table give no faces and no extra triangles.
    always_comb
    begin
        if (item.cell_type inside {[SHAPE_FIRST:SHAPE_LAST]})
        begin
            base_faces = SHAPE_FACES[row];
            base_extra = SHAPE_EXTRA[row];
        end
        else
        begin
            base_faces = {vco_pkg::NumFaces{vco_pkg::FACE_NONE}};
            base_extra = '0;
        end
    end

    vco_turn u_turn_x (
        .axis        (vco_pkg::AXIS_X),
        .turns       (item.turns_x),
        .faces_in    (base_faces),
        .corners_in  (vco_pkg::CORNER_IDENTITY),
        .faces_out   (faces_x),
        .corners_out (corners_x)
    );

    vco_turn u_turn_y (
        .axis        (vco_pkg::AXIS_Y),
        .turns       (item.turns_y),
        .faces_in    (faces_x),
        .corners_in  (corners_x),
        .faces_out   (faces_y),
        .corners_out (corners_y)
    );

    vco_turn u_turn_z (
        .axis        (vco_pkg::AXIS_Z),
        .turns       (item.turns_z),
        .faces_in    (faces_y),
        .corners_in  (corners_y),
        .faces_out   (faces_z),
        .corners_out (corners_z)
    );

    assign result.faces   = faces_z;
    assign result.corners = corners_z;
    assign result.extra   = base_extra;

endmodule
